FILE: rtl/mkps_pkg.sv
// Shared types, constants and key map for the 4x3 keypad scanner.
`timescale 1ns / 1ps

package mkps_pkg;

  localparam int unsigned ROW_W    = 2;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned ROWS     = 4;
  localparam int unsigned CODE_W   = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned IN_DW    = 8;
  localparam int unsigned OUT_DW   = 16;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  // Register index, taken from paddr[2] (word address)
  localparam logic REG_SETTLE_TICKS = 1'b0;
  localparam logic [COUNT_W-1:0] SETTLE_RESET = 8'd10;

  localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [COUNT_W-1:0] settle_count;
    logic               gap_phase;
    logic               release_mode;
    logic [CODE_W-1:0]  held_key;
  } scan_state_t;

  typedef struct packed {
    logic [ROWS-1:0]   row_drive_n;
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
  } scan_result_t;

  // Rows 1..4 by columns 1..3: "*0#", "789", "456", "123"
  function automatic logic [CODE_W-1:0] key_ascii(input logic [ROW_W-1:0] row,
                                                  input logic [1:0] col);
    logic [CODE_W-1:0] code;
    code = 7'h00;
    unique case ({row, col})
      4'b00_00: code = 7'h2A; // '*'
      4'b00_01: code = 7'h30; // '0'
      4'b00_10: code = 7'h23; // '#'
      4'b01_00: code = 7'h37; // '7'
      4'b01_01: code = 7'h38; // '8'
      4'b01_10: code = 7'h39; // '9'
      4'b10_00: code = 7'h34; // '4'
      4'b10_01: code = 7'h35; // '5'
      4'b10_10: code = 7'h36; // '6'
      4'b11_00: code = 7'h31; // '1'
      4'b11_01: code = 7'h32; // '2'
      4'b11_10: code = 7'h33; // '3'
      default:  code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/mkps_step.sv
// Next-state and result logic for one scan tick.
`timescale 1ns / 1ps

module mkps_step (
  input  mkps_pkg::scan_state_t                 cur,
  input  logic [mkps_pkg::COL_W-1:0]            col_n,
  input  logic [mkps_pkg::COUNT_W-1:0]          settle_ticks,
  output mkps_pkg::scan_state_t                 nxt,
  output mkps_pkg::scan_result_t                res
);
  import mkps_pkg::*;

  logic [COUNT_W:0] count_inc;
  logic             key_hit;
  logic [1:0]       col_sel;

  assign count_inc = {1'b0, cur.settle_count} + {{COUNT_W{1'b0}}, 1'b1};

  // Column 1 has priority
  always_comb begin
    key_hit = 1'b1;
    col_sel = 2'd0;
    priority if (!col_n[0]) begin
      col_sel = 2'd0;
    end else if (!col_n[1]) begin
      col_sel = 2'd1;
    end else if (!col_n[2]) begin
      col_sel = 2'd2;
    end else begin
      key_hit = 1'b0;
    end
  end

  always_comb begin
    nxt = cur;
    res.row_drive_n = ~(ROWS'(1) << cur.row_index);
    res.key_valid   = 1'b0;
    res.key_code    = '0;
    priority if (count_inc < {1'b0, settle_ticks}) begin
      nxt.settle_count = count_inc[COUNT_W-1:0];
    end else if (!cur.gap_phase) begin
      nxt.settle_count = '0;
      if (key_hit) begin
        if (!cur.release_mode) begin
          nxt.held_key     = key_ascii(cur.row_index, col_sel);
          nxt.release_mode = 1'b1;
        end
        nxt.row_index = '0;
        nxt.gap_phase = 1'b0;
      end else begin
        nxt.gap_phase = 1'b1;
      end
    end else begin
      nxt.settle_count = '0;
      nxt.gap_phase    = 1'b0;
      if (cur.row_index == LAST_ROW) begin
        // empty pass completed: report the held key once
        if (cur.release_mode) begin
          res.key_valid     = 1'b1;
          res.key_code      = cur.held_key;
          nxt.release_mode  = 1'b0;
        end
        nxt.row_index = '0;
      end else begin
        nxt.row_index = cur.row_index + ROW_W'(1);
      end
    end
  end

endmodule

FILE: rtl/matrix_keypad_scan_press_release.sv
// Top level of the 4x3 matrix keypad scanner with press-and-release reporting.
`timescale 1ns / 1ps

// Each input transfer is one timer tick carrying the active-low column sample;
// each tick yields exactly one output transfer with the row drive for that tick
// and, on the tick that closes the first fully empty scan pass after a press,
// the ASCII code of the pressed key with key_valid set. One tick is taken per
// clock: the scan state advances in a single step of logic, and the result
// lands in an output register, so a new tick is accepted every cycle while the
// output side keeps up. settle_ticks (address 0) must be written over the APB-style port
// only while no tick is in flight; the block does not enforce this. 0 behaves like 1.

module matrix_keypad_scan_press_release (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream, tdata: col_n[2:0], zero pad [7:3]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mkps_pkg::IN_DW-1:0]     in_tdata,
  // result stream, tdata: row_drive_n[3:0], key_valid[4], key_code[11:5], zero pad [15:12]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mkps_pkg::OUT_DW-1:0]    out_tdata,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mkps_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [mkps_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [mkps_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import mkps_pkg::*;

  logic [COUNT_W-1:0] settle_ticks_r;
  scan_state_t        state_r, state_nxt;
  scan_result_t       step_res;
  scan_result_t       res_r;
  logic               out_valid_r;
  logic               in_xfer;
  logic               cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (cfg_paddr[2] == REG_SETTLE_TICKS);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SETTLE_TICKS) begin
      cfg_prdata = {{(CFG_DW-COUNT_W){1'b0}}, settle_ticks_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RESET;
    end else if (cfg_write) begin
      settle_ticks_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  mkps_step u_step (
    .cur          (state_r),
    .col_n        (in_tdata[COL_W-1:0]),
    .settle_ticks (settle_ticks_r),
    .nxt          (state_nxt),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-ROWS-1-CODE_W){1'b0}},
                       res_r.key_code, res_r.key_valid, res_r.row_drive_n};

endmodule

FILE: tb/mkps_scan_checker.sv
// Checker for the keypad scanner: predicts every tick's result and compares the output stream.
`timescale 1ns / 1ps

module mkps_scan_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [mkps_pkg::IN_DW-1:0]   in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [mkps_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mkps_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [mkps_pkg::CFG_DW-1:0]  cfg_pwdata,
  input  logic [mkps_pkg::CFG_DW-1:0]  cfg_prdata,
  input  logic                         cfg_pready,
  output int                           mismatch_count,
  output int                           ticks_pending,
  output int                           ticks_checked,
  output int                           keys_reported,
  output logic [mkps_pkg::ROW_W-1:0]   next_row
);
  import mkps_pkg::*;

  // Key legends, row 1 first, three columns per row
  localparam logic [12*8-1:0] KEY_LEGENDS = "*0#789456123";

  localparam int unsigned VALID_BIT = ROWS;
  localparam int unsigned CODE_LSB  = ROWS + 1;
  localparam int unsigned PAD_LSB   = ROWS + 1 + CODE_W;

  logic [COUNT_W-1:0] settle_cfg;
  logic [COUNT_W-1:0] settle_cnt;
  logic [ROW_W-1:0]   row_idx;
  logic               in_gap;
  logic               awaiting_release;
  logic [CODE_W-1:0]  held_code;
  scan_result_t       tick_results_q[$];
  scan_result_t       want;

  task automatic flag(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
  endtask

  // Advances the scan by one tick and returns what the block should emit for it
  function automatic scan_result_t scan_tick(input logic [COL_W-1:0] cols);
    scan_result_t     res;
    logic [COUNT_W:0] count_up;
    int               hit;
    int               slot;
    res.row_drive_n = ~(4'b0001 << row_idx);
    res.key_valid   = 1'b0;
    res.key_code    = '0;
    count_up = settle_cnt + 1'b1;
    if (count_up < {1'b0, settle_cfg}) begin
      settle_cnt = count_up[COUNT_W-1:0];
    end else if (!in_gap) begin
      hit = -1;
      // lowest numbered column wins
      for (int c = COL_W - 1; c >= 0; c--) if (!cols[c]) hit = c;
      settle_cnt = '0;
      if (hit >= 0) begin
        if (!awaiting_release) begin
          slot = row_idx * COL_W + hit;
          held_code = KEY_LEGENDS[(11 - slot) * 8 +: CODE_W];
          awaiting_release = 1'b1;
        end
        row_idx = '0;
        in_gap  = 1'b0;
      end else begin
        in_gap = 1'b1;
      end
    end else begin
      settle_cnt = '0;
      in_gap     = 1'b0;
      if (row_idx == LAST_ROW) begin
        if (awaiting_release) begin
          res.key_valid    = 1'b1;
          res.key_code     = held_code;
          awaiting_release = 1'b0;
        end
        row_idx = '0;
      end else begin
        row_idx = row_idx + 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settle_cfg       = SETTLE_RESET;
      settle_cnt       = '0;
      row_idx          = '0;
      in_gap           = 1'b0;
      awaiting_release = 1'b0;
      held_code        = '0;
      tick_results_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        ticks_checked++;
        if (tick_results_q.size() == 0) begin
          flag("unexpected result", '0, 32'(out_tdata));
        end else begin
          want = tick_results_q.pop_front();
          if (out_tdata[ROWS-1:0] != want.row_drive_n ||
              out_tdata[VALID_BIT] != want.key_valid ||
              out_tdata[PAD_LSB-1:CODE_LSB] != want.key_code ||
              out_tdata[OUT_DW-1:PAD_LSB] != '0)
            flag("result", 32'({want.key_code, want.key_valid, want.row_drive_n}),
                 32'(out_tdata));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_SETTLE_TICKS) begin
        if (cfg_pwrite)
          settle_cfg = cfg_pwdata[COUNT_W-1:0];
        else if (cfg_prdata != CFG_DW'(settle_cfg))
          flag("settle_ticks readback", CFG_DW'(settle_cfg), cfg_prdata);
      end
      if (in_tvalid && in_tready) begin
        want = scan_tick(in_tdata[COL_W-1:0]);
        if (want.key_valid) keys_reported++;
        tick_results_q.push_back(want);
      end
    end
    ticks_pending = tick_results_q.size();
    next_row      = row_idx;
  end

endmodule

FILE: tb/tb_matrix_keypad_scan_press_release.sv
// Testbench top for the keypad scanner: clock, reset, keypad stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_matrix_keypad_scan_press_release;
  import mkps_pkg::*;

  localparam logic        REG_SPARE = 1'b1;  // second word, writes there have no effect
  localparam int          HOLD_AT   = 2500;
  localparam int          HOLD_LEN  = 300;
  // one column sample per character, low three bits of each
  localparam logic [25*8-1:0] DIRECTED = "0653777777777777477777777";

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;   // col_n[2:0], zero pad [7:3]
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;  // row_drive_n[3:0], key_valid[4], key_code[11:5], pad [15:12]
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  int                  mismatches;
  int                  pending;
  int                  checked;
  int                  keys;
  logic [ROW_W-1:0]    scan_row;
  int                  cur_settle;

  matrix_keypad_scan_press_release u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  mkps_scan_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .mismatch_count(mismatches),
    .ticks_pending(pending),
    .ticks_checked(checked),
    .keys_reported(keys),
    .next_row(scan_row)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Columns seen on the row being driven, given the set of keys held down
  function automatic logic [COL_W-1:0] keypad_cols(input logic [11:0] pressed,
                                                   input logic [ROW_W-1:0] row);
    logic [COL_W-1:0] cols;
    cols = '1;
    for (int k = 0; k < COL_W; k++) if (pressed[row * COL_W + k]) cols[k] = 1'b0;
    return cols;
  endfunction

  task automatic pause_ticks(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // from_pad: columns come from the held keys and the row about to be scanned
  task automatic offer_tick(input logic from_pad, input logic [11:0] pressed,
                            input logic [COL_W-1:0] raw);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DW'(from_pad ? keypad_cols(pressed, scan_row) : raw);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    pause_ticks(1);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic reg_sel, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_settle(input int value);
    drain();
    cfg_access(1'b1, REG_SETTLE_TICKS, CFG_DW'(value));
    cfg_access(1'b0, REG_SETTLE_TICKS, '0);
    cur_settle = value;
  endtask

  // Press and release episodes on a virtual keypad, with bursts of ticks and random gaps
  task automatic scan_keypad(input int n);
    logic [11:0] pressed;
    logic        noisy;
    int          episode_left;
    int          burst_left;
    int          pass_len;
    int          kind;
    pressed      = '0;
    noisy        = 1'b0;
    episode_left = 0;
    burst_left   = 0;
    pass_len     = 8 * ((cur_settle == 0) ? 1 : cur_settle);
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        pause_ticks($urandom_range(0, 5));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
      end
      burst_left--;
      if (episode_left == 0) begin
        kind  = $urandom_range(0, 9);
        noisy = (kind >= 8);
        if (kind < 4) begin
          pressed = 12'b1 << $urandom_range(0, 11);
          if (kind == 3) pressed |= 12'b1 << $urandom_range(0, 11);
          episode_left = $urandom_range(1, 3 * pass_len);
        end else if (kind < 8) begin
          pressed      = '0;
          episode_left = $urandom_range(pass_len / 2, 3 * pass_len);
        end else begin
          episode_left = $urandom_range(1, pass_len / 2);
        end
      end
      episode_left--;
      offer_tick(!noisy, pressed, COL_W'($urandom_range(0, 7)));
    end
  endtask

  // Receiver: stall pattern changes per window, plus long hold-offs at fixed cycle counts
  initial begin : receiver
    int cyc;
    int hold_left;
    int win_left;
    int pat;
    cyc        = 0;
    hold_left  = 0;
    win_left   = 0;
    pat        = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_AT || cyc == 3 * HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (win_left == 0) begin
          win_left = $urandom_range(8, 80);
          pat      = $urandom_range(0, 3);
        end
        win_left--;
        case (pat)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cur_settle  = SETTLE_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    cfg_access(1'b0, REG_SETTLE_TICKS, '0);
    // zero settle time: every tick samples or advances
    set_settle(0);
    for (int i = 0; i < 25; i++) offer_tick(1'b0, '0, DIRECTED[(24 - i) * 8 +: COL_W]);
    drain();
    cfg_access(1'b1, REG_SPARE, CFG_DW'(3));
    cfg_access(1'b0, REG_SETTLE_TICKS, '0);

    set_settle(SETTLE_RESET);
    scan_keypad(200);
    set_settle(1);
    scan_keypad(450);
    set_settle(2);
    scan_keypad(175);
    drain();
    scan_keypad(175);
    set_settle(255);
    scan_keypad(200);
    set_settle(3);
    scan_keypad(300);
    set_settle(6);
    scan_keypad(150);

    pause_ticks(1);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    $display("Checked %0d ticks, %0d of them reporting a released key,", checked, keys);
    $display("over settle times 0, 1, 2, 3, 6, 10 and 255 and one write to the spare register");
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
